// ===== sv/countdown_timer_bank_macros.svh =====
// Assertion macros for the countdown timer bank.
// Included by the top level only; expects clk and rst in scope.
`ifndef COUNTDOWN_TIMER_BANK_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, off while reset is high
`define CTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also active during reset
`define CTB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTB_ASSERT(lbl, prop, msg)
`define CTB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/ctb_pkg.sv =====
// Shared constants, codes and controller/datapath interface structs
// for the countdown timer bank. No dependencies.
package ctb_pkg;

  // Defaults
  localparam int NUM_TIMERS_DEF = 40;
  localparam int MS_PER_SECOND  = 1000;
  localparam logic [7:0] ADC_PERIOD_RST = 8'd5;
  localparam logic [7:0] NO_HANDLE      = 8'hFF;

  // Opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_SETCLK = 3'd6;
  localparam logic [2:0] OP_RDCLK  = 3'd7;

  // Result status codes
  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_BAD_HANDLE = 2'd1;
  localparam logic [1:0] STS_FULL       = 2'd2;

  // Query results
  localparam logic [1:0] TS_EXPIRED = 2'd0;
  localparam logic [1:0] TS_RUNNING = 2'd1;
  localparam logic [1:0] TS_STOPPED = 2'd2;
  localparam logic [1:0] TS_INVALID = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;    // latch the incoming item
    logic rd_slot;   // read the addressed slot
    logic rd_first;  // read slot 0 (start of tick walk)
    logic rd_next;   // read the slot after the last one read
    logic scan_wr;   // write back the decremented slot just read
    logic finish;    // commit the item and load the result register
  } ctb_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [2:0] op;
    logic       handle_ok;
    logic       scan_last;
    logic       out_valid;
  } ctb_sts_t;

endpackage

// ===== sv/ctb_ctrl.sv =====
// Sequencer for the countdown timer bank: accepts an item, walks the slot
// memory on a tick, and hands the result over. Depends on ctb_pkg.
module ctb_ctrl
  import ctb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_ready,
  input  ctb_sts_t sts,
  output logic     in_ready,
  output ctb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DISPATCH = 2'd1;
  localparam logic [1:0] S_SCAN     = 2'd2;
  localparam logic [1:0] S_FINISH   = 2'd3;

  logic [1:0] state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == OP_TICK) begin
          cmd.rd_first = 1'b1;
          state_next   = S_SCAN;
        end else begin
          // stop, query and read need the slot entry
          if (sts.handle_ok &&
              (sts.op == OP_STOP || sts.op == OP_QUERY || sts.op == OP_READ)) begin
            cmd.rd_slot = 1'b1;
          end
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_wr = 1'b1;
        if (sts.scan_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_FINISH: begin
        if (!sts.out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ctb_datapath.sv =====
// Datapath of the countdown timer bank: slot memory with valid bits,
// clock and converter counters, allocation count, result register.
// Depends on ctb_pkg.
module ctb_datapath
  import ctb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctb_cmd_t    cmd,
  output ctb_sts_t    sts,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic [2:0]  opcode,
  input  logic [7:0]  handle,
  input  logic [31:0] load_value,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [7:0]  granted_handle,
  output logic [1:0]  timer_state,
  output logic [31:0] remaining_ms,
  output logic [31:0] clock_seconds,
  output logic        adc_start
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);
  localparam logic [CNT_W-1:0]  NUM_CNT   = CNT_W'(NUM_TIMERS);
  localparam logic [7:0]        NUM_H     = 8'(NUM_TIMERS);
  localparam logic [9:0]        LAST_MS   = 10'(MS_PER_SECOND - 1);

  // Latched item
  logic [2:0]  op;
  logic [7:0]  hnd;
  logic [31:0] load;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= opcode;
      hnd  <= handle;
      load <= load_value;
    end
  end

  logic              handle_ok;
  logic [SLOT_W-1:0] slot_sel;

  assign handle_ok = !hnd[7] && ({1'b0, hnd[6:0]} < NUM_H);
  assign slot_sel  = hnd[SLOT_W-1:0];

  // Slot memory: {running, count}; valid bits stand for the reset value
  logic [32:0]           mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] slot_valid;
  logic [32:0]           rd_data;
  logic                  rd_hit;
  logic [SLOT_W-1:0]     rd_addr_q;
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [32:0]           wr_data;

  assign rd_en = cmd.rd_slot | cmd.rd_first | cmd.rd_next;

  always_comb begin
    rd_addr = slot_sel;
    if (cmd.rd_first) begin
      rd_addr = '0;
    end else if (cmd.rd_next) begin
      rd_addr = rd_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_hit    <= slot_valid[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

  logic [32:0] entry;
  logic        ent_run;
  logic [31:0] ent_cnt;

  assign entry   = rd_hit ? rd_data : '0;
  assign ent_run = entry[32];
  assign ent_cnt = entry[31:0];

  // Scalar state
  logic [7:0]       adc_period;
  logic [9:0]       millis;
  logic [31:0]      seconds;
  logic [7:0]       adc_cnt;
  logic [CNT_W-1:0] alloc_cnt;

  logic [9:0]       millis_next;
  logic [31:0]      seconds_next;
  logic [7:0]       adc_cnt_next;
  logic [CNT_W-1:0] alloc_cnt_next;
  logic [7:0]       adc_inc;

  logic [1:0]  status_n;
  logic [7:0]  granted_n;
  logic [1:0]  tstate_n;
  logic [31:0] remain_n;
  logic        adc_n;

  assign adc_inc = adc_cnt + 8'd1;

  // Item effects and result fields
  always_comb begin
    millis_next    = millis;
    seconds_next   = seconds;
    adc_cnt_next   = adc_cnt;
    alloc_cnt_next = alloc_cnt;
    status_n       = STS_OK;
    granted_n      = NO_HANDLE;
    tstate_n       = TS_EXPIRED;
    remain_n       = '0;
    adc_n          = 1'b0;
    unique case (op) inside
      OP_TICK: begin
        if (millis >= LAST_MS) begin
          millis_next  = '0;
          seconds_next = seconds + 32'd1;
        end else begin
          millis_next = millis + 10'd1;
        end
        if (adc_inc >= adc_period) begin
          adc_n        = 1'b1;
          adc_cnt_next = '0;
        end else begin
          adc_cnt_next = adc_inc;
        end
      end
      OP_ALLOC: begin
        // slots are never freed, so the used slots are always a prefix
        if (alloc_cnt < NUM_CNT) begin
          granted_n      = 8'(alloc_cnt);
          alloc_cnt_next = alloc_cnt + 1'b1;
        end else begin
          status_n = STS_FULL;
        end
      end
      OP_START, OP_STOP: begin
        if (!handle_ok) begin
          status_n = STS_BAD_HANDLE;
        end
      end
      OP_QUERY: begin
        if (!handle_ok) begin
          status_n = STS_BAD_HANDLE;
          tstate_n = TS_INVALID;
        end else if (!ent_run) begin
          tstate_n = TS_STOPPED;
        end else if (ent_cnt != 32'd0) begin
          tstate_n = TS_RUNNING;
        end
      end
      OP_READ: begin
        if (!handle_ok) begin
          status_n = STS_BAD_HANDLE;
        end else if (ent_run) begin
          remain_n = ent_cnt;
        end
      end
      OP_SETCLK: begin
        seconds_next = load;
        millis_next  = '0;
      end
      OP_RDCLK: begin
      end
      default: begin
      end
    endcase
  end

  // Memory write: tick walk, start load, stop clears the running flag
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = {ent_run, ent_cnt - 32'(ent_cnt != 32'd0)};
    if (cmd.scan_wr) begin
      wr_en = 1'b1;
    end else if (cmd.finish && handle_ok && op == OP_START) begin
      wr_en   = 1'b1;
      wr_addr = slot_sel;
      wr_data = {1'b1, load};
    end else if (cmd.finish && handle_ok && op == OP_STOP) begin
      wr_en   = 1'b1;
      wr_addr = slot_sel;
      wr_data = {1'b0, ent_cnt};
    end
  end

  // Control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_period <= ADC_PERIOD_RST;
      millis     <= '0;
      seconds    <= '0;
      adc_cnt    <= '0;
      alloc_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        adc_period <= cfg_data;
      end
      if (cmd.finish) begin
        millis    <= millis_next;
        seconds   <= seconds_next;
        adc_cnt   <= adc_cnt_next;
        alloc_cnt <= alloc_cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= status_n;
      granted_handle <= granted_n;
      timer_state    <= tstate_n;
      remaining_ms   <= remain_n;
      clock_seconds  <= seconds_next;
      adc_start      <= adc_n;
    end
  end

  assign sts.op        = op;
  assign sts.handle_ok = handle_ok;
  assign sts.scan_last = (rd_addr_q == LAST_SLOT);
  assign sts.out_valid = out_valid;

endmodule

// ===== sv/countdown_timer_bank.sv =====
// Bank of NUM_TIMERS millisecond countdown timers with a seconds clock and
// a converter-start divider. One command item in, one result item out.
// A tick walks the slot memory one slot per cycle through a single read
// and a single write port; every other command skips the walk. Results
// sit in an output register; a new item is taken once the previous one
// has been committed there. No clearing pass after reset: per-slot valid
// bits stand for the zeroed slots.
`include "countdown_timer_bank_macros.svh"

module countdown_timer_bank
  import ctb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  handle,
  input  logic [31:0] load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  granted_handle,
  output logic [1:0]  timer_state,
  output logic [31:0] remaining_ms,
  output logic [31:0] clock_seconds,
  output logic        adc_start
);

  ctb_cmd_t cmd;
  ctb_sts_t sts;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  ctb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .handle         (handle),
    .load_value     (load_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .granted_handle (granted_handle),
    .timer_state    (timer_state),
    .remaining_ms   (remaining_ms),
    .clock_seconds  (clock_seconds),
    .adc_start      (adc_start)
  );

  // Result carries no slot grant
  logic no_grant;

  assign no_grant = (granted_handle == NO_HANDLE);

  // One item at a time: accepting closes the input until the result is committed
  `CTB_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "item accepted while busy")
  // A granted slot always reports success
  `CTB_ASSERT(a_grant_ok, out_valid && !no_grant |-> status == STS_OK, "grant without ok status")
  // Invalid query state only with a bad-handle status
  `CTB_ASSERT(a_inv_state, out_valid && timer_state == TS_INVALID |-> status == STS_BAD_HANDLE, "bad state")
  // Converter pulse only on tick results, which grant nothing
  `CTB_ASSERT(a_adc_tick, out_valid && adc_start |-> status == STS_OK && no_grant, "stray pulse")
  // Out of reset the block is ready and holds no result
  `CTB_ASSERT_RST(a_reset, rst |=> in_ready && !out_valid, "busy after reset")

endmodule
